// ===== src/polar_to_rectangular_assert.svh =====
// Assertion macros used by the checker file of the converter.
`ifndef POLAR_TO_RECTANGULAR_ASSERT_SVH
`define POLAR_TO_RECTANGULAR_ASSERT_SVH

// Checked only while reset is released.
`define P2R_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define P2R_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/p2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2r_pkg
// Constants, constant tables and stage types of the polar to rectangular
// converter.
// ----------------------------------------------------------------------------
package p2r_pkg;

    localparam int CORDIC_STAGES = 18;
    localparam int MAX_STAGES    = 30;
    localparam int NUM_ROT       = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    localparam logic [31:0] LOG2_10_DIV10_Q32 = 32'd1426757253;
    localparam logic [31:0] DEG_PER_RAD_Q24   = 32'd961263669;
    localparam logic [20:0] TURN_Q10          = 21'd368640;
    localparam logic [20:0] HALF_TURN_Q10     = 21'd184320;
    localparam logic [20:0] QUARTER_TURN_Q10  = 21'd92160;
    localparam logic [21:0] ANGLE_BIAS        = 22'd737280;

    typedef struct packed {
        logic               is_db;
        logic signed [23:0] level;
        logic signed [7:0]  n;
        logic [29:0]        frac;
        logic [31:0]        p;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } t_stage;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q30, each step the truncated root of the one before
    function automatic logic [31:0] pow_frac(input int k);
        logic [63:0] p;
        p = 64'd2 << 30;
        for (int j = 1; j <= MAX_STAGES; j++) begin
            if (j <= k) begin
                p = isqrt64(p << 30);
            end
        end
        return p[31:0];
    endfunction

    function automatic logic [63:0] cordic_gain();
        logic [63:0] gain;
        logic [63:0] one;
        logic [63:0] f;
        gain = 64'd1 << 30;
        one  = 64'd1 << 30;
        for (int k = 0; k < MAX_STAGES; k++) begin
            if (k < NUM_ROT) begin
                f    = isqrt64((one + (one >> (2 * k))) << 30);
                gain = (gain * f) >> 30;
            end
        end
        return gain;
    endfunction

    localparam logic [63:0] GAIN       = cordic_gain();
    localparam logic [63:0] UNIT_START = (64'd1 << 60) / GAIN;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'd754974720;
            1:       a = 32'd445687602;
            2:       a = 32'd235489088;
            3:       a = 32'd119537938;
            4:       a = 32'd60000934;
            5:       a = 32'd30029717;
            6:       a = 32'd15018523;
            7:       a = 32'd7509720;
            8:       a = 32'd3754917;
            9:       a = 32'd1877466;
            default: a = 32'((64'(DEG_PER_RAD_Q24) + (64'd1 << (i - 1))) >> i);
        endcase
        return a;
    endfunction

endpackage

// ===== src/polar_to_rectangular.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 35 register stages (one entry stage, 30 power/rotation stages,
// four scaling stages) from request accept to result valid.
// Throughput: one request per cycle while the output does not stall; stages
// hold under stall and bubbles close up, so 35 stage registers bound in-flight.
// Reset: synchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
// polar_to_rectangular
// Level (linear or decibel) and angle in degrees to saturated Q15.16 parts.
// ----------------------------------------------------------------------------
module polar_to_rectangular
    import p2r_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_mode,
    input  wire logic signed [23:0] i_level,
    input  wire logic signed [19:0] i_angle_deg,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_real_part,
    output logic signed [31:0]      o_imag_part,
    output logic                    o_saturated
);

    localparam int NSTG = MAX_STAGES + 5;

    logic [NSTG-1:0] w_v;
    logic [NSTG:0]   w_g;
    t_stage          w_d [0:MAX_STAGES];

    // advance chain: a stage moves when it is empty or its successor moves
    always_comb begin
        w_g[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_g[k] = !w_v[k] || w_g[k+1];
        end
    end
    assign o_in_ready = w_g[0];

    // ---------------- entry stage ----------------
    logic               r_v0;
    t_stage             r_s0;
    t_stage             n_s0;
    logic signed [55:0] w_e;
    logic [20:0]        w_a;
    logic [20:0]        w_r;
    logic signed [20:0] w_rs;
    logic signed [20:0] w_rf;
    logic               w_flip;

    always_comb begin
        w_e = 56'(i_level) * 56'($signed({1'b0, LOG2_10_DIV10_Q32}));
        w_a = 21'($unsigned(22'(i_angle_deg) + $signed(ANGLE_BIAS)));
        if (w_a >= 21'(3 * 368640)) begin
            w_r = w_a - 21'(3 * 368640);
        end else if (w_a >= 21'(2 * 368640)) begin
            w_r = w_a - 21'(2 * 368640);
        end else if (w_a >= TURN_Q10) begin
            w_r = w_a - TURN_Q10;
        end else begin
            w_r = w_a;
        end
        if (w_r > HALF_TURN_Q10) begin
            w_rs = $signed(w_r) - $signed(TURN_Q10);
        end else begin
            w_rs = $signed(w_r);
        end
        w_flip = 1'b0;
        w_rf   = w_rs;
        if (w_rs > $signed(QUARTER_TURN_Q10)) begin
            w_rf   = w_rs - $signed(HALF_TURN_Q10);
            w_flip = 1'b1;
        end else if (w_rs < -$signed(QUARTER_TURN_Q10)) begin
            w_rf   = w_rs + $signed(HALF_TURN_Q10);
            w_flip = 1'b1;
        end
        n_s0.is_db = i_mode;
        n_s0.level = i_level;
        n_s0.n     = w_e[55:48];
        n_s0.frac  = w_e[47:18];
        n_s0.p     = 32'd1 << 30;
        n_s0.x     = $signed(UNIT_START[33:0]);
        n_s0.y     = '0;
        n_s0.z     = 34'(w_rf) <<< 14;
        n_s0.flip  = w_flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_g[0]) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_g[0]) begin
            r_s0 <= n_s0;
        end
    end

    assign w_v[0] = r_v0;
    assign w_d[0] = r_s0;

    // ---------------- power / rotation stages ----------------
    for (genvar j = 0; j < MAX_STAGES; j++) begin : g_stage
        p2r_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_g[j+1]),
            .i_valid (w_v[j]),
            .i_d     (w_d[j]),
            .i_sh    (5'(j)),
            .i_atan  (atan_entry(j)),
            .i_pow   (pow_frac(j + 1)),
            .i_rot   ((j < NUM_ROT) ? 1'b1 : 1'b0),
            .o_valid (w_v[j+1]),
            .o_d     (w_d[j+1])
        );
    end

    // ---------------- scaling stages ----------------
    localparam int T1 = MAX_STAGES + 1;

    t_stage             w_last;
    logic signed [31:0] r_mant1;
    logic signed [33:0] r_x1;
    logic signed [33:0] r_y1;
    logic [6:0]         r_sh1;
    logic signed [8:0]  w_sh;
    logic signed [65:0] r_pre2;
    logic signed [65:0] r_pim2;
    logic [6:0]         r_sh2;
    logic signed [65:0] r_re3;
    logic signed [65:0] r_im3;
    logic signed [31:0] n_re;
    logic signed [31:0] n_im;
    logic               n_sat;
    logic signed [31:0] r_re4;
    logic signed [31:0] r_im4;
    logic               r_sat4;
    logic [3:0]         r_vt;

    assign w_last = w_d[MAX_STAGES];

    always_comb begin
        w_sh = 9'sd44 - 9'(w_last.n);
        if (!w_last.is_db) begin
            w_sh = 9'sd30;
        end
        if (w_sh > 9'sd65) begin
            w_sh = 9'sd65;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= '0;
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (w_g[T1+k]) begin
                    r_vt[k] <= w_v[T1+k-1];
                end
            end
        end
    end

    assign w_v[NSTG-4 +: 4] = r_vt;

    always_ff @(posedge i_clk) begin
        if (w_g[T1]) begin
            r_mant1 <= w_last.is_db ? $signed(w_last.p) : 32'(w_last.level);
            r_x1    <= w_last.flip ? -w_last.x : w_last.x;
            r_y1    <= w_last.flip ? -w_last.y : w_last.y;
            r_sh1   <= w_sh[6:0];
        end
        if (w_g[T1+1]) begin
            r_pre2 <= 66'(r_mant1) * 66'(r_x1);
            r_pim2 <= 66'(r_mant1) * 66'(r_y1);
            r_sh2  <= r_sh1;
        end
        if (w_g[T1+2]) begin
            r_re3 <= r_pre2 >>> r_sh2;
            r_im3 <= r_pim2 >>> r_sh2;
        end
        if (w_g[T1+3]) begin
            r_re4  <= n_re;
            r_im4  <= n_im;
            r_sat4 <= n_sat;
        end
    end

    // clip to signed 32 bits
    always_comb begin
        n_sat = 1'b0;
        n_re  = r_re3[31:0];
        n_im  = r_im3[31:0];
        if (r_re3[65:31] != {35{r_re3[65]}}) begin
            n_sat = 1'b1;
            n_re  = r_re3[65] ? 32'sh80000000 : 32'sh7fffffff;
        end
        if (r_im3[65:31] != {35{r_im3[65]}}) begin
            n_sat = 1'b1;
            n_im  = r_im3[65] ? 32'sh80000000 : 32'sh7fffffff;
        end
    end

    assign o_out_valid = w_v[NSTG-1];
    assign o_real_part = r_re4;
    assign o_imag_part = r_im4;
    assign o_saturated = r_sat4;

endmodule
`default_nettype wire

// ===== src/p2r_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2r_stage
// One pipeline stage: one step of the fractional power-of-two product and,
// when i_rot is set, one CORDIC rotation step.
// ----------------------------------------------------------------------------
module p2r_stage
    import p2r_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_stage      i_d,
    input  wire logic [4:0]  i_sh,
    input  wire logic [31:0] i_atan,
    input  wire logic [31:0] i_pow,
    input  wire logic        i_rot,
    output logic             o_valid,
    output t_stage           o_d
);

    logic        r_valid;
    t_stage      r_d;
    t_stage      n_d;
    logic [63:0] w_prod;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [33:0] w_at;

    always_comb begin
        n_d    = i_d;
        w_prod = 64'(i_d.p) * 64'(i_pow);
        w_dx   = i_d.y >>> i_sh;
        w_dy   = i_d.x >>> i_sh;
        w_at   = $signed({2'b00, i_atan});
        if (i_d.frac[29]) begin
            n_d.p = w_prod[61:30];
        end
        n_d.frac = {i_d.frac[28:0], 1'b0};
        if (i_rot) begin
            if (!i_d.z[33]) begin
                n_d.x = i_d.x - w_dx;
                n_d.y = i_d.y + w_dy;
                n_d.z = i_d.z - w_at;
            end else begin
                n_d.x = i_d.x + w_dx;
                n_d.y = i_d.y - w_dy;
                n_d.z = i_d.z + w_at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule
`default_nettype wire

// ===== src/p2r_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2r_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "polar_to_rectangular_assert.svh"
module p2r_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] o_real_part,
    input wire logic signed [31:0] o_imag_part,
    input wire logic               o_saturated
);

    `P2R_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "valid after reset")
    `P2R_ASSERT(a_empty_ready, !o_out_valid |-> o_in_ready, "ready low with no result")
    `P2R_ASSERT(a_sat_clip, (o_out_valid && o_saturated) |-> (o_real_part == 32'sh7fffffff || o_real_part == 32'sh80000000 || o_imag_part == 32'sh7fffffff || o_imag_part == 32'sh80000000), "flag without clipped part")
    `P2R_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_real_part) && $stable(o_imag_part)), "stalled result changed")

endmodule

bind polar_to_rectangular p2r_checker u_p2r_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_real_part (o_real_part),
    .o_imag_part (o_imag_part),
    .o_saturated (o_saturated)
);
`default_nettype wire

// ===== tb/polar_to_rectangular_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_to_rectangular_tb
// Drives level/angle requests through the converter with random gaps and
// output stalls, predicts each saturated Q15.16 pair with a bit-exact
// fixed-point CORDIC, and compares results in order.
// ----------------------------------------------------------------------------
module polar_to_rectangular_tb;

    import p2r_pkg::*;

    localparam longint TURN_DEG    = 368640;
    localparam longint HALF_DEG    = 184320;
    localparam longint QUARTER_DEG = 92160;
    localparam longint DB_TO_LOG2  = 1426757253;
    localparam longint RAD_TO_DEG  = 961263669;
    localparam int     TOP_STAGES  = 30;

    class rect_scoreboard;
        longint unsigned frac_pow[TOP_STAGES + 1];
        longint          unit_x;
        int              rot_stages;
        int              errors;
        logic signed [31:0] want_real[$];
        logic signed [31:0] want_imag[$];
        logic               want_sat[$];

        function new();
            longint unsigned gain;
            longint unsigned one;
            longint unsigned f;
            errors     = 0;
            rot_stages = (CORDIC_STAGES > TOP_STAGES) ? TOP_STAGES : CORDIC_STAGES;
            frac_pow[0] = 64'd2 << 30;
            for (int k = 1; k <= TOP_STAGES; k++) begin
                frac_pow[k] = int_sqrt(frac_pow[k - 1] << 30);
            end
            one  = 64'd1 << 30;
            gain = one;
            for (int k = 0; k < rot_stages; k++) begin
                f    = int_sqrt((one + (one >> (2 * k))) << 30);
                gain = (gain * f) >> 30;
            end
            unit_x = longint'((64'd1 << 60) / gain);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v_in);
            longint unsigned v;
            longint unsigned root;
            longint unsigned b;
            v    = v_in;
            root = 0;
            b    = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v    = v - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
            return root;
        endfunction

        function longint floor_shift(longint v, int s);
            if (s <= 0) return v;
            if (s > 62) return (v < 0) ? -64'sd1 : 64'sd0;
            return v >>> s;
        endfunction

        function longint arctan_q24(int i);
            case (i)
                0: return 754974720;
                1: return 445687602;
                2: return 235489088;
                3: return 119537938;
                4: return 60000934;
                5: return 30029717;
                6: return 15018523;
                7: return 7509720;
                8: return 3754917;
                9: return 1877466;
                default: return (RAD_TO_DEG + (64'sd1 <<< (i - 1))) >>> i;
            endcase
        endfunction

        function longint clip_q15(longint v, inout logic sat);
            if (v > 64'sd2147483647) begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // Compute the expected pair for one accepted request.
        function void note_request(logic mode, logic signed [23:0] level,
                                   logic signed [19:0] angle);
            longint lv;
            longint a;
            longint mant;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint re;
            longint im;
            logic [63:0] u;
            longint unsigned p;
            int shift;
            int n;
            logic flip;
            logic sat;
            lv   = level;
            a    = angle;
            flip = 1'b0;
            sat  = 1'b0;
            if (!mode) begin
                mant  = lv;
                shift = 30;
            end else begin
                u = lv * DB_TO_LOG2 + (64'sd64 <<< 48);
                n = int'(u >> 48) - 64;
                p = 64'd1 << 30;
                for (int k = 1; k <= TOP_STAGES; k++) begin
                    if (u[48 - k]) p = (p * frac_pow[k]) >> 30;
                end
                mant  = longint'(p);
                shift = 44 - n;
            end

            a = (a + 2 * TURN_DEG) % TURN_DEG;
            if (a > HALF_DEG) a = a - TURN_DEG;
            if (a > QUARTER_DEG) begin
                a    = a - HALF_DEG;
                flip = 1'b1;
            end else if (a < -QUARTER_DEG) begin
                a    = a + HALF_DEG;
                flip = 1'b1;
            end

            x = unit_x;
            y = 0;
            z = a * 16384;
            for (int i = 0; i < rot_stages; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_q24(i);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_q24(i);
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            re = clip_q15(floor_shift(mant * x, shift), sat);
            im = clip_q15(floor_shift(mant * y, shift), sat);
            want_real.insert(want_real.size(), re[31:0]);
            want_imag.insert(want_imag.size(), im[31:0]);
            want_sat.insert(want_sat.size(), sat);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic signed [31:0] re, logic signed [31:0] im, logic sat);
            logic signed [31:0] er;
            logic signed [31:0] ei;
            logic               es;
            if (want_real.size() == 0) begin
                report($sformatf("unexpected result re=%0d im=%0d", re, im));
                return;
            end
            er = want_real.pop_front();
            ei = want_imag.pop_front();
            es = want_sat.pop_front();
            if (re !== er) report($sformatf("real %0d, want %0d", re, er));
            if (im !== ei) report($sformatf("imag %0d, want %0d", im, ei));
            if (sat !== es) report($sformatf("saturated %0b, want %0b", sat, es));
        endtask

        function int pending();
            return want_real.size();
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_mode      = 1'b0;
    logic signed [23:0] i_level     = '0;
    logic signed [19:0] i_angle_deg = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_real_part;
    logic signed [31:0] o_imag_part;
    logic               o_saturated;

    logic           calm = 1'b0;
    logic           live = 1'b0;
    rect_scoreboard board = new();

    polar_to_rectangular DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_level     (i_level),
        .i_angle_deg (i_angle_deg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_real_part (o_real_part),
        .o_imag_part (o_imag_part),
        .o_saturated (o_saturated)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (live) begin
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_real_part, o_imag_part, o_saturated);
            end
            i_out_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // Hold the request until accepted; idle beforehand at random.
    task send_request(logic mode, logic signed [23:0] level, logic signed [19:0] angle);
        if (!calm && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_level     <= level;
        i_angle_deg <= angle;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(mode, level, angle);
    endtask

    initial begin
        logic signed [23:0] lv;
        int pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        live    <= 1'b1;
        @(posedge i_clk);

        // magnitude extremes and the fold points of the angle
        send_request(1'b0, 24'sd65536, 20'sd0);
        send_request(1'b0, 24'sd65536, 20'sd92160);
        send_request(1'b0, 24'sd65536, 20'sd184320);
        send_request(1'b0, 24'sd65536, -20'sd184320);
        send_request(1'b0, 24'sd65536, 20'sd276480);
        send_request(1'b0, 24'sd65536, -20'sd92160);
        send_request(1'b0, 24'sd8388607, 20'sd46080);
        send_request(1'b0, -24'sd8388608, 20'sd524287);
        send_request(1'b0, -24'sd65536, -20'sd524288);
        send_request(1'b0, 24'sd0, 20'sd12345);
        send_request(1'b0, 24'sd8388607, -20'sd524288);
        // decibel: unity, 10 dB, huge, deeply negative
        send_request(1'b1, 24'sd0, 20'sd0);
        send_request(1'b1, 24'sd655360, 20'sd46080);
        send_request(1'b1, 24'sd8388607, 20'sd0);
        send_request(1'b1, 24'sd8388607, 20'sd184320);
        send_request(1'b1, 24'sd6291456, -20'sd46080);
        send_request(1'b1, -24'sd6553600, 20'sd138240);
        send_request(1'b1, -24'sd8388608, 20'sd524287);
        send_request(1'b1, 24'sd1, -20'sd1);

        for (int n = 0; n < 450; n++) begin
            calm <= (n >= 150 && n < 250);
            pick = $urandom_range(9);
            if (pick < 4) begin
                lv = 24'($urandom());
                send_request(1'b0, lv, 20'($urandom()));
            end else if (pick < 7) begin
                // realistic dB range, roughly +/-60 dB
                lv = 24'($signed($urandom_range(7864320)) - 32'sd3932160);
                send_request(1'b1, lv, 20'($urandom()));
            end else begin
                lv = 24'($urandom());
                send_request(1'b1, lv, 20'($urandom()));
            end
        end
        i_in_valid <= 1'b0;
        calm       <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("polar_to_rectangular_tb: clean");
        end else begin
            $display("polar_to_rectangular_tb: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("polar_to_rectangular_tb: errors");
        $finish;
    end

endmodule
